### rtl/mcpb_pkg.sv
package mcpb_pkg;

    localparam int NUM_OUTPUTS = 32;
    localparam int COUNT_WIDTH = 16;
    localparam int LEVELS_WIDTH = 32;
    localparam int CHAN_WIDTH = 5;
    localparam int DUR_WIDTH = 16;

    localparam logic [2:0] OP_TICK   = 3'd0;
    localparam logic [2:0] OP_SET    = 3'd1;
    localparam logic [2:0] OP_PULSE  = 3'd2;
    localparam logic [2:0] OP_BLINK  = 3'd3;
    localparam logic [2:0] OP_TOGGLE = 3'd4;
    localparam logic [2:0] OP_ALLOFF = 3'd5;

    typedef logic [COUNT_WIDTH-1:0] cnt_t;
    typedef logic [LEVELS_WIDTH-1:0] levels_t;

    typedef struct packed {
        logic       en;
        logic [2:0] op;
        logic       level;
        cnt_t       dur;
        logic       dur_nz;
    } lane_cmd_t;

endpackage

### rtl/multi_channel_pulse_blink_outputs_core.sv
// Channel  Direction  Beat contents
// s_       in         operation, channel, level, duration
// m_       out        output_levels (bit n is the level of output n)
//
// One beat is accepted every cycle while no m_ready stall holds the pipeline;
// each result passes the input register and then the result register.
// All output lanes update in parallel in the cycle an item leaves the input
// register. A stall on m_ready holds the result register, and the input
// register then takes one more beat before s_ready drops.
// Synchronous active-low reset clears the lane levels, counters and periods; the output levels register is not cleared.
module multi_channel_pulse_blink_outputs_core (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [2:0]                            s_operation,
    input  logic [mcpb_pkg::CHAN_WIDTH-1:0]       s_channel,
    input  logic                                  s_level,
    input  logic [mcpb_pkg::DUR_WIDTH-1:0]        s_duration,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [mcpb_pkg::LEVELS_WIDTH-1:0]     m_output_levels
);

    logic                                in_valid_reg;
    logic [2:0]                          op_reg;
    logic [mcpb_pkg::CHAN_WIDTH-1:0]     chan_reg;
    logic                                level_reg;
    logic [mcpb_pkg::DUR_WIDTH-1:0]      dur_reg;
    logic                                out_valid_reg;
    mcpb_pkg::levels_t                   levels_reg;
    mcpb_pkg::levels_t                   levels_next;
    logic [mcpb_pkg::NUM_OUTPUTS-1:0]    lane_level;
    logic [31:0]                         dur_ext;
    logic                                advance;
    mcpb_pkg::lane_cmd_t                 cmd;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_output_levels = levels_reg;

    assign dur_ext = {16'b0, dur_reg};

    always_comb begin
        cmd.en     = advance;
        cmd.op     = op_reg;
        cmd.level  = level_reg;
        cmd.dur    = dur_ext[mcpb_pkg::COUNT_WIDTH-1:0];
        cmd.dur_nz = (dur_ext[mcpb_pkg::COUNT_WIDTH-1:0] != '0);
    end

    for (genvar n = 0; n < mcpb_pkg::NUM_OUTPUTS; n++) begin : g_lane
        mcpb_lane u_lane (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .cmd        (cmd),
            .hit        (chan_reg == mcpb_pkg::CHAN_WIDTH'(n)),
            .level_next (lane_level[n])
        );
    end

    always_comb begin
        levels_next = '0;
        for (int n = 0; n < mcpb_pkg::NUM_OUTPUTS; n++) begin
            levels_next[n] = lane_level[n];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg    <= s_operation;
            chan_reg  <= s_channel;
            level_reg <= s_level;
            dur_reg   <= s_duration;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            levels_reg <= levels_next;
        end
    end

    a_hold_input: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && out_valid_reg && !m_ready |=> in_valid_reg)
        else $error("pending input beat lost during output stall");

    a_ready_low: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_valid_reg && out_valid_reg)
        else $error("input stalled with a free stage");

    a_all_off: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && op_reg == mcpb_pkg::OP_ALLOFF |=> m_valid && m_output_levels == '0)
        else $error("all off left an output set");

    a_result_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid)
        else $error("processed item produced no result");

endmodule

### rtl/mcpb_lane.sv
module mcpb_lane (
    input  logic              aclk,
    input  logic              aresetn,
    input  mcpb_pkg::lane_cmd_t cmd,
    input  logic              hit,
    output logic              level_next
);

    logic          level_reg;
    mcpb_pkg::cnt_t cnt_reg;
    mcpb_pkg::cnt_t cnt_next;
    mcpb_pkg::cnt_t period_reg;
    mcpb_pkg::cnt_t period_next;
    mcpb_pkg::cnt_t cnt_dec;

    assign cnt_dec = cnt_reg - mcpb_pkg::cnt_t'(1);

    always_comb begin
        level_next  = level_reg;
        cnt_next    = cnt_reg;
        period_next = period_reg;
        case (cmd.op)
            mcpb_pkg::OP_TICK: begin
                if (cnt_reg != '0) begin
                    if (cnt_dec == '0) begin
                        level_next = ~level_reg;
                        cnt_next   = period_reg;
                    end else begin
                        cnt_next = cnt_dec;
                    end
                end
            end
            mcpb_pkg::OP_SET: begin
                if (hit) begin
                    level_next  = cmd.level;
                    cnt_next    = '0;
                    period_next = '0;
                end
            end
            mcpb_pkg::OP_PULSE, mcpb_pkg::OP_BLINK: begin
                if (hit && cmd.dur_nz) begin
                    if (cnt_reg == '0) begin
                        level_next = ~level_reg;
                    end
                    cnt_next    = cmd.dur;
                    period_next = (cmd.op == mcpb_pkg::OP_BLINK) ? cmd.dur : '0;
                end
            end
            mcpb_pkg::OP_TOGGLE: begin
                if (hit) begin
                    level_next  = ~level_reg;
                    cnt_next    = '0;
                    period_next = '0;
                end
            end
            mcpb_pkg::OP_ALLOFF: begin
                level_next  = 1'b0;
                cnt_next    = '0;
                period_next = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg  <= 1'b0;
            cnt_reg    <= '0;
            period_reg <= '0;
        end else if (cmd.en) begin
            level_reg  <= level_next;
            cnt_reg    <= cnt_next;
            period_reg <= period_next;
        end
    end

endmodule
